FILE: src/aarch64_rela_relocation_patcher_assert.svh
// Assertion macros shared by the relocation patcher RTL.
// Expects aclk and aresetn in the scope of the including module.
`ifndef AARCH64_RELA_RELOCATION_PATCHER_ASSERT_SVH
`define AARCH64_RELA_RELOCATION_PATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("arrp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ARRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("arrp: next-cycle check failed");

`endif

FILE: src/arrp_pkg.sv
// Types, codes and the relocation type table of the relocation patcher.
// No dependencies; imported by every module of the block.
package arrp_pkg;

    localparam int unsigned CMD_COUNT = 38;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_DATA = 3'd1,
        K_MOVU = 3'd2,
        K_MOVS = 3'd3,
        K_IMM  = 3'd4
    } kind_e;

    typedef enum logic [1:0] {
        OP_ABS  = 2'd0,
        OP_PREL = 2'd1,
        OP_PAGE = 2'd2
    } op_e;

    typedef enum logic [2:0] {
        F_ADR = 3'd0,
        F_12  = 3'd1,
        F_14  = 3'd2,
        F_19  = 3'd3,
        F_26  = 3'd4
    } field_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVF   = 2'd1,
        ST_UNSUP = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    localparam logic REG_TARGET_BASE = 1'b0;
    localparam logic REG_TARGET_SIZE = 1'b1;

    typedef struct packed {
        kind_e       kind;
        op_e         op;
        logic [5:0]  lsb;
        logic [6:0]  len;
        field_e      field;
        logic        check;
    } rtype_t;

    typedef struct packed {
        logic [63:0] target_base;
        logic [63:0] target_size;
    } cfg_t;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [63:0] offset;
        logic [63:0] val;
        logic [63:0] place;
        logic [31:0] old_word;
    } item_t;

    typedef struct packed {
        logic [63:0] new_bits;
        logic [3:0]  write_bytes;
        status_e     status;
    } res_t;

    function automatic rtype_t arrp_decode(input logic [5:0] cmd);
        rtype_t d;
        d = '{K_NONE, OP_ABS, 6'd0, 7'd0, F_ADR, 1'b0};
        unique case (cmd)
            6'd1:    d = '{K_DATA, OP_ABS,  6'd0,  7'd64, F_ADR, 1'b0};
            6'd2:    d = '{K_DATA, OP_ABS,  6'd0,  7'd32, F_ADR, 1'b1};
            6'd3:    d = '{K_DATA, OP_ABS,  6'd0,  7'd16, F_ADR, 1'b1};
            6'd4:    d = '{K_DATA, OP_PREL, 6'd0,  7'd64, F_ADR, 1'b0};
            6'd5:    d = '{K_DATA, OP_PREL, 6'd0,  7'd32, F_ADR, 1'b1};
            6'd6:    d = '{K_DATA, OP_PREL, 6'd0,  7'd16, F_ADR, 1'b1};
            6'd7:    d = '{K_MOVU, OP_ABS,  6'd0,  7'd16, F_ADR, 1'b1};
            6'd8:    d = '{K_MOVU, OP_ABS,  6'd0,  7'd16, F_ADR, 1'b0};
            6'd9:    d = '{K_MOVU, OP_ABS,  6'd16, 7'd16, F_ADR, 1'b1};
            6'd10:   d = '{K_MOVU, OP_ABS,  6'd16, 7'd16, F_ADR, 1'b0};
            6'd11:   d = '{K_MOVU, OP_ABS,  6'd32, 7'd16, F_ADR, 1'b1};
            6'd12:   d = '{K_MOVU, OP_ABS,  6'd32, 7'd16, F_ADR, 1'b0};
            6'd13:   d = '{K_MOVU, OP_ABS,  6'd48, 7'd16, F_ADR, 1'b0};
            6'd14:   d = '{K_MOVS, OP_ABS,  6'd0,  7'd16, F_ADR, 1'b1};
            6'd15:   d = '{K_MOVS, OP_ABS,  6'd16, 7'd16, F_ADR, 1'b1};
            6'd16:   d = '{K_MOVS, OP_ABS,  6'd32, 7'd16, F_ADR, 1'b1};
            6'd17:   d = '{K_IMM,  OP_PREL, 6'd2,  7'd19, F_19,  1'b1};
            6'd18:   d = '{K_IMM,  OP_PREL, 6'd0,  7'd21, F_ADR, 1'b1};
            6'd19:   d = '{K_IMM,  OP_PAGE, 6'd12, 7'd21, F_ADR, 1'b1};
            6'd20:   d = '{K_IMM,  OP_PAGE, 6'd12, 7'd21, F_ADR, 1'b0};
            6'd21:   d = '{K_IMM,  OP_ABS,  6'd0,  7'd12, F_12,  1'b0};
            6'd22:   d = '{K_IMM,  OP_ABS,  6'd0,  7'd12, F_12,  1'b0};
            6'd23:   d = '{K_IMM,  OP_PREL, 6'd2,  7'd14, F_14,  1'b1};
            6'd24:   d = '{K_IMM,  OP_PREL, 6'd2,  7'd19, F_19,  1'b1};
            6'd25:   d = '{K_IMM,  OP_PREL, 6'd2,  7'd26, F_26,  1'b1};
            6'd26:   d = '{K_IMM,  OP_PREL, 6'd2,  7'd26, F_26,  1'b1};
            6'd27:   d = '{K_IMM,  OP_ABS,  6'd1,  7'd11, F_12,  1'b0};
            6'd28:   d = '{K_IMM,  OP_ABS,  6'd2,  7'd10, F_12,  1'b0};
            6'd29:   d = '{K_IMM,  OP_ABS,  6'd3,  7'd9,  F_12,  1'b0};
            6'd30:   d = '{K_MOVS, OP_PREL, 6'd0,  7'd16, F_ADR, 1'b1};
            6'd31:   d = '{K_MOVU, OP_PREL, 6'd0,  7'd16, F_ADR, 1'b0};
            6'd32:   d = '{K_MOVS, OP_PREL, 6'd16, 7'd16, F_ADR, 1'b1};
            6'd33:   d = '{K_MOVU, OP_PREL, 6'd16, 7'd16, F_ADR, 1'b0};
            6'd34:   d = '{K_MOVS, OP_PREL, 6'd32, 7'd16, F_ADR, 1'b1};
            6'd35:   d = '{K_MOVU, OP_PREL, 6'd32, 7'd16, F_ADR, 1'b0};
            6'd36:   d = '{K_MOVS, OP_PREL, 6'd48, 7'd16, F_ADR, 1'b0};
            6'd37:   d = '{K_IMM,  OP_ABS,  6'd4,  7'd8,  F_12,  1'b0};
            default: d = '{K_NONE, OP_ABS,  6'd0,  7'd0,  F_ADR, 1'b0};
        endcase
        return d;
    endfunction

endpackage

FILE: src/arrp_cfg.sv
// APB register file holding the section base address and section size.
// Depends on arrp_pkg for the register indexes and the cfg_t struct.
module arrp_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output arrp_pkg::cfg_t     cfg
);
    import arrp_pkg::*;

    logic [63:0] base_reg, base_next;
    logic [63:0] size_reg, size_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        base_next = base_reg;
        size_next = size_reg;
        if (wr_en) begin
            unique case (paddr[3])
                REG_TARGET_BASE: base_next = pwdata;
                REG_TARGET_SIZE: size_next = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            size_reg <= '0;
        end else begin
            base_reg <= base_next;
            size_reg <= size_next;
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_TARGET_BASE: prdata = base_reg;
            REG_TARGET_SIZE: prdata = size_reg;
            default:         prdata = base_reg;
        endcase
    end

    assign cfg.target_base = base_reg;
    assign cfg.target_size = size_reg;

endmodule

FILE: src/arrp_calc.sv
// Relocation datapath: value selection, range and overflow checks and field insertion.
// Depends on arrp_pkg for the type table and the item and result structs.
module arrp_calc (
    input  arrp_pkg::item_t    item,
    input  logic [63:0]        target_size,
    output arrp_pkg::res_t     res
);
    import arrp_pkg::*;

    rtype_t             d;
    logic               unsup;
    logic [3:0]         width;
    logic               out_of_range;
    logic [63:0]        r;
    logic signed [63:0] rs;
    logic [63:0]        s;
    logic [63:0]        t;
    logic [6:0]         tsh;
    logic [63:0]        lenmask;
    logic [63:0]        imm;
    logic [15:0]        imm16;
    logic [31:0]        insn;
    logic               t_zero;
    logic               t_ones;
    logic               t_one;
    logic               bad;
    logic [63:0]        bits;

    assign d     = arrp_decode(item.cmd);
    assign unsup = ({1'b0, item.cmd} >= 7'(CMD_COUNT));

    always_comb begin
        case (d.kind)
            K_NONE:  width = 4'd0;
            K_DATA:  width = d.len[6:3];
            default: width = 4'd4;
        endcase
    end

    assign out_of_range = (item.offset > target_size)
                       || ({60'd0, width} > (target_size - item.offset));

    always_comb begin
        case (d.op)
            OP_PREL: r = item.val - item.place;
            OP_PAGE: r = {item.val[63:12], 12'd0} - {item.place[63:12], 12'd0};
            default: r = item.val;
        endcase
    end

    assign rs = r;
    assign s  = rs >>> d.lsb;

    always_comb begin
        case (d.kind) inside
            K_DATA:          tsh = d.len - 7'd1;
            K_MOVU, K_MOVS:  tsh = {1'b0, d.lsb} + 7'd16;
            default:         tsh = {1'b0, d.lsb} + d.len - 7'd1;
        endcase
    end

    assign t       = rs >>> tsh;
    assign t_zero  = (t == 64'd0);
    assign t_ones  = &t;
    assign t_one   = (t == 64'd1);
    assign lenmask = ~({64{1'b1}} << d.len);
    assign imm     = s & lenmask;
    assign imm16   = (d.kind == K_MOVS && s[63]) ? ~s[15:0] : s[15:0];

    always_comb begin
        insn = item.old_word;
        case (d.kind)
            K_MOVU: begin
                insn[20:5] = imm16;
            end
            K_MOVS: begin
                insn[30:29] = s[63] ? 2'b00 : 2'b10;
                insn[20:5]  = imm16;
            end
            default: begin
                case (d.field)
                    F_ADR: begin
                        insn[30:29] = imm[1:0];
                        insn[23:5]  = imm[20:2];
                    end
                    F_12:    insn[21:10] = imm[11:0];
                    F_14:    insn[18:5]  = imm[13:0];
                    F_19:    insn[23:5]  = imm[18:0];
                    default: insn[25:0]  = imm[25:0];
                endcase
            end
        endcase
    end

    always_comb begin
        case (d.kind)
            K_DATA:  bad = !(t_zero || t_ones || t_one);
            K_MOVU:  bad = !t_zero;
            default: bad = !(t_zero || t_ones);
        endcase
    end

    assign bits = (d.kind == K_DATA) ? (r & lenmask) : {32'd0, insn};

    always_comb begin
        if (unsup) begin
            res = '{64'd0, 4'd0, ST_UNSUP};
        end else if (out_of_range) begin
            res = '{64'd0, 4'd0, ST_RANGE};
        end else if (d.kind == K_NONE) begin
            res = '{64'd0, 4'd0, ST_OK};
        end else begin
            res = '{bits, width, (d.check && bad) ? ST_OVF : ST_OK};
        end
    end

endmodule

FILE: src/aarch64_rela_relocation_patcher.sv
// Top level of the AArch64 RELA relocation patcher: stream ports, APB port.
// Depends on arrp_pkg, arrp_cfg, arrp_calc and the assertion macro header.
// The block takes one relocation request per clock and returns one result per request: the
// request is captured in an input register (with S + A and the place P already summed),
// patched by the datapath and held in a result register that parts the two stream sides.
// Sustained rate is one request per cycle; it is set by those two register stages, which
// both advance whenever the result register is empty or being taken. Configuration must
// be written through the APB port while no request is in flight; the block does not check.
`include "aarch64_rela_relocation_patcher_assert.svh"

module aarch64_rela_relocation_patcher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // offset [63:0], symbol_value [127:64], addend [191:128], old_word [223:192]
    input  logic [223:0] s_tdata,
    // cmd [5:0]
    input  logic [5:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_bits [63:0], write_bytes [67:64], zero fill [71:68]
    output logic [71:0]  m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import arrp_pkg::*;

    cfg_t   cfg;
    item_t  in_item;
    item_t  s1_reg, s1_next;
    logic   s1_valid_reg, s1_valid_next;
    res_t   calc_res;
    res_t   out_reg, out_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_adv;
    logic   s_accept;
    logic   out_width_ok;
    logic   out_rejected;
    logic   out_empty;

    arrp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arrp_calc u_calc (
        .item        (s1_reg),
        .target_size (cfg.target_size),
        .res         (calc_res)
    );

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_adv;
    assign s_accept = s_tvalid && s_tready;

    assign in_item.cmd      = s_tuser;
    assign in_item.offset   = s_tdata[63:0];
    assign in_item.val      = s_tdata[127:64] + s_tdata[191:128];
    assign in_item.place    = cfg.target_base + s_tdata[63:0];
    assign in_item.old_word = s_tdata[223:192];

    always_comb begin
        s1_next        = s1_reg;
        s1_valid_next  = s1_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_adv) begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                out_next = calc_res;
            end
            s1_valid_next = 1'b0;
        end
        if (s_accept) begin
            s1_next       = in_item;
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.write_bytes, out_reg.new_bits};
    assign m_tuser  = out_reg.status;

    assign out_width_ok = (out_reg.write_bytes == 4'd0) || (out_reg.write_bytes == 4'd2)
                       || (out_reg.write_bytes == 4'd4) || (out_reg.write_bytes == 4'd8);
    assign out_rejected = (out_reg.status == ST_UNSUP) || (out_reg.status == ST_RANGE);
    assign out_empty    = (out_reg.write_bytes == 4'd0) && (out_reg.new_bits == 64'd0);

    `ARRP_ASSERT_NOW(a_empty_stage_takes_input, !s1_valid_reg, s_tready)
    `ARRP_ASSERT_NEXT(a_stalled_stage_keeps_item, s1_valid_reg && !out_adv, s1_valid_reg)
    `ARRP_ASSERT_NOW(a_write_width_legal, out_valid_reg, out_width_ok)
    `ARRP_ASSERT_NOW(a_rejected_writes_nothing, out_valid_reg && out_rejected, out_empty)

endmodule
